FILE: rtl/spe_pkg.sv
package spe_pkg;

    localparam int FW = 24;
    localparam int IN_DATA_W = 152;
    localparam int ROWS_W = 9;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd2;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_LOSS = 2'd1;
    localparam logic [1:0] OP_FINAL = 2'd2;
    localparam logic [1:0] OP_INITIAL = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_DIVS, S_CHKS, S_DSEG, S_DIVG, S_NEXT_STEP, S_SETREM,
        S_SINIT, S_SPROBE, S_SCMP, S_IREAD, S_MULE, S_DIVE, S_WDE,
        S_MULN, S_DIVN, S_WDN, S_SUM, S_MULL, S_LOSS_DONE,
        S_FIN_OK, S_FIN_OOR, S_FIN_TMS
    } state_t;

    typedef enum logic [1:0] {
        PH_QUERY, PH_LOOP, PH_REM
    } phase_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD_ROW, CMD_LATCH, CMD_DIV_STEPS, CMD_SET_STEPS,
        CMD_DIV_SEG, CMD_SET_SEG, CMD_MUL_REM, CMD_SET_REM,
        CMD_SINIT, CMD_SWRAP, CMD_SREAD, CMD_SNEXT, CMD_SHIT, CMD_IREAD,
        CMD_MUL_E, CMD_DIV_INT, CMD_SET_SE, CMD_MUL_N, CMD_SET_SN,
        CMD_SUM10, CMD_MUL_LOSS, CMD_APPLY,
        CMD_OUT_OK, CMD_OUT_OOR, CMD_OUT_TMS
    } cmd_t;

    typedef struct packed {
        logic probe_ok;
        logic phase2;
        logic hit;
        logic div_busy;
        logic q_zero;
        logic q_too_big;
        logic step_zero;
        logic loop_more;
    } dp_status_t;

endpackage

FILE: rtl/spe_ctrl.sv
module spe_ctrl
    import spe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t st,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic out_valid_reg, out_valid_next;
    logic fire, out_free, fin_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign fire = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign fin_fire = out_free && (state_reg == S_FIN_OK || state_reg == S_FIN_OOR
                                   || state_reg == S_FIN_TMS);
    assign out_valid_next = fin_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_QUERY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire && in_op != OP_LOAD)
                begin
                    if (in_op == OP_LOSS)
                    begin
                        state_next = S_SINIT;
                        phase_next = PH_QUERY;
                    end
                    else
                    begin
                        state_next = S_CHK;
                        phase_next = PH_LOOP;
                    end
                end
            end
            S_CHK:       state_next = st.step_zero ? S_FIN_TMS : S_DIVS;
            S_DIVS:      if (!st.div_busy) state_next = S_CHKS;
            S_CHKS:
            begin
                if (st.q_too_big)
                    state_next = S_FIN_TMS;
                else if (st.q_zero)
                    state_next = S_NEXT_STEP;
                else
                    state_next = S_DSEG;
            end
            S_DSEG:      state_next = S_DIVG;
            S_DIVG:      if (!st.div_busy) state_next = S_NEXT_STEP;
            S_NEXT_STEP: state_next = st.loop_more ? S_SINIT : S_SETREM;
            S_SETREM:
            begin
                state_next = S_SINIT;
                phase_next = PH_REM;
            end
            S_SINIT:     state_next = S_SPROBE;
            S_SPROBE:
            begin
                if (st.probe_ok)
                    state_next = S_SCMP;
                else if (st.phase2)
                    state_next = S_FIN_OOR;
            end
            S_SCMP:      state_next = st.hit ? S_IREAD : S_SPROBE;
            S_IREAD:     state_next = S_MULE;
            S_MULE:      state_next = S_DIVE;
            S_DIVE:      state_next = S_WDE;
            S_WDE:       if (!st.div_busy) state_next = S_MULN;
            S_MULN:      state_next = S_DIVN;
            S_DIVN:      state_next = S_WDN;
            S_WDN:       if (!st.div_busy) state_next = S_SUM;
            S_SUM:       state_next = S_MULL;
            S_MULL:      state_next = S_LOSS_DONE;
            S_LOSS_DONE:
            begin
                unique case (phase_reg)
                    PH_LOOP:  state_next = S_NEXT_STEP;
                    default:  state_next = S_FIN_OK;
                endcase
            end
            S_FIN_OK, S_FIN_OOR, S_FIN_TMS:
                if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = CMD_NONE;
        unique case (state_reg)
            S_IDLE:      if (fire) cmd = (in_op == OP_LOAD) ? CMD_LOAD_ROW : CMD_LATCH;
            S_CHK:       if (!st.step_zero) cmd = CMD_DIV_STEPS;
            S_CHKS:      if (!st.q_too_big) cmd = CMD_SET_STEPS;
            S_DSEG:      cmd = CMD_DIV_SEG;
            S_DIVG:      if (!st.div_busy) cmd = CMD_SET_SEG;
            S_NEXT_STEP: if (!st.loop_more) cmd = CMD_MUL_REM;
            S_SETREM:    cmd = CMD_SET_REM;
            S_SINIT:     cmd = CMD_SINIT;
            S_SPROBE:
            begin
                if (st.probe_ok)
                    cmd = CMD_SREAD;
                else if (!st.phase2)
                    cmd = CMD_SWRAP;
            end
            S_SCMP:      cmd = st.hit ? CMD_SHIT : CMD_SNEXT;
            S_IREAD:     cmd = CMD_IREAD;
            S_MULE:      cmd = CMD_MUL_E;
            S_DIVE:      cmd = CMD_DIV_INT;
            S_WDE:       if (!st.div_busy) cmd = CMD_SET_SE;
            S_MULN:      cmd = CMD_MUL_N;
            S_DIVN:      cmd = CMD_DIV_INT;
            S_WDN:       if (!st.div_busy) cmd = CMD_SET_SN;
            S_SUM:       cmd = CMD_SUM10;
            S_MULL:      cmd = CMD_MUL_LOSS;
            S_LOSS_DONE: if (phase_reg != PH_QUERY) cmd = CMD_APPLY;
            S_FIN_OK:    if (out_free) cmd = CMD_OUT_OK;
            S_FIN_OOR:   if (out_free) cmd = CMD_OUT_OOR;
            S_FIN_TMS:   if (out_free) cmd = CMD_OUT_TMS;
            default:     cmd = CMD_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN_OK
            || $past(state_reg) == S_FIN_OOR || $past(state_reg) == S_FIN_TMS))
        else $error("result appeared outside a finish state");
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_op != OP_LOAD) |=> state_reg != S_IDLE)
        else $error("accepted query did not start");
    a_no_result_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_op == OP_LOAD) |=> state_reg == S_IDLE)
        else $error("load beat left idle");
`endif

endmodule

FILE: rtl/spe_dp.sv
module spe_dp
    import spe_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_STEPS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [1:0]           in_op,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic                 cfg_we,
    input  logic [ROWS_W-1:0]    cfg_data,
    output dp_status_t           st,
    output logic [FW-1:0]        result_energy,
    output logic [1:0]           result_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int MA = 29;
    localparam int PW = MA + FW;

    logic [FW-1:0] mem_e [TABLE_DEPTH];
    logic [FW-1:0] mem_a [TABLE_DEPTH];
    logic [FW-1:0] mem_n [TABLE_DEPTH];

    logic [ROWS_W-1:0] rows_reg;
    logic [AW-1:0] hint_reg, p_reg;
    logic phase2_reg, neg_reg, div_busy_reg;
    logic [1:0] op_reg;
    logic [FW-1:0] e_reg, path_reg, step_reg, dist_reg;
    logic [SW-1:0] steps_reg, cnt_reg;
    logic [FW-1:0] rd_e0, rd_e1, rd_a0, rd_a1, rd_n0, rd_n1;
    logic [PW-1:0] prod_reg;
    logic [FW-1:0] se_reg, sn_reg;
    logic [MA-1:0] sum10_reg;
    logic [4:0] div_cnt_reg;
    logic [FW-1:0] div_rem_reg, div_lo_reg, div_dvs_reg, div_q_reg;
    logic [FW-1:0] res_reg;
    logic [1:0] st_reg;

    logic [RW-1:0] rows_eff, pp1, hintx;
    logic [AW-1:0] p_start, p_inc;
    logic [FW-1:0] num, den, dya, dyn, loss;
    logic [FW:0] div_t, sum_e, sum_se;
    logic div_ge, div_start;
    logic [FW-1:0] in_e, in_path, in_step, w_e, w_a, w_n;
    logic [7:0] in_idx;

    assign in_idx  = in_data[7:0];
    assign w_e     = in_data[31:8];
    assign w_a     = in_data[55:32];
    assign w_n     = in_data[79:56];
    assign in_e    = in_data[103:80];
    assign in_path = in_data[127:104];
    assign in_step = in_data[151:128];

    assign rows_eff = (32'(rows_reg) > TABLE_DEPTH) ? RW'(TABLE_DEPTH) : RW'(rows_reg);
    assign pp1 = RW'(p_reg) + RW'(1);
    assign hintx = RW'(hint_reg);
    assign p_start = (hint_reg != '0) ? hint_reg - AW'(1) : '0;
    assign p_inc = p_reg + AW'(1);

    assign num = e_reg - rd_e0;
    assign den = rd_e1 - rd_e0;
    assign dya = (rd_a1 >= rd_a0) ? rd_a1 - rd_a0 : rd_a0 - rd_a1;
    assign dyn = (rd_n1 >= rd_n0) ? rd_n1 - rd_n0 : rd_n0 - rd_n1;
    assign loss = (|prod_reg[PW-1:FW+16]) ? {FW{1'b1}} : prod_reg[FW+15:16];
    assign sum_e = {1'b0, e_reg} + {1'b0, loss};
    assign sum_se = {1'b0, se_reg} + {1'b0, sn_reg};

    assign div_t = {div_rem_reg, div_lo_reg[FW-1]};
    assign div_ge = (div_t >= {1'b0, div_dvs_reg});
    assign div_start = (cmd == CMD_DIV_STEPS) || (cmd == CMD_DIV_SEG) || (cmd == CMD_DIV_INT);

    always_comb
    begin
        st.probe_ok  = phase2_reg ? (pp1 < hintx && pp1 < rows_eff) : (pp1 < rows_eff);
        st.phase2    = phase2_reg;
        st.hit       = (e_reg >= rd_e0) && (e_reg < rd_e1);
        st.div_busy  = div_busy_reg;
        st.q_zero    = (div_q_reg == '0);
        st.q_too_big = 32'(div_q_reg) > MAX_STEPS;
        st.step_zero = (step_reg == '0);
        st.loop_more = (cnt_reg < steps_reg);
    end

    // Table memories: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD_ROW && 32'(in_idx) < TABLE_DEPTH)
        begin
            mem_e[AW'(in_idx)] <= w_e;
            mem_a[AW'(in_idx)] <= w_a;
            mem_n[AW'(in_idx)] <= w_n;
        end
        if (cmd == CMD_SREAD)
        begin
            rd_e0 <= mem_e[p_reg];
            rd_e1 <= mem_e[p_inc];
        end
        if (cmd == CMD_IREAD)
        begin
            rd_a0 <= mem_a[p_reg];
            rd_a1 <= mem_a[p_inc];
            rd_n0 <= mem_n[p_reg];
            rd_n1 <= mem_n[p_inc];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            hint_reg <= '0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rows_reg <= cfg_data;
            if (cmd == CMD_LATCH && in_op == OP_INITIAL)
                hint_reg <= '0;
            else if (cmd == CMD_SHIT)
                hint_reg <= p_reg;
            if (div_start)
                div_busy_reg <= 1'b1;
            else if (div_busy_reg && div_cnt_reg == '0)
                div_busy_reg <= 1'b0;
        end
    end

    // Restoring divider, one quotient bit a cycle; the dividend's upper half
    // is always below the divisor, so the quotient fits in 24 bits.
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_cnt_reg <= 5'(FW - 1);
            div_q_reg <= '0;
            case (cmd)
                CMD_DIV_STEPS:
                begin
                    div_rem_reg <= '0;
                    div_lo_reg <= path_reg;
                    div_dvs_reg <= step_reg;
                end
                CMD_DIV_SEG:
                begin
                    div_rem_reg <= '0;
                    div_lo_reg <= path_reg;
                    div_dvs_reg <= FW'(steps_reg);
                end
                default:
                begin
                    div_rem_reg <= prod_reg[2*FW-1:FW];
                    div_lo_reg <= prod_reg[FW-1:0];
                    div_dvs_reg <= den;
                end
            endcase
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_ge ? FW'(div_t - {1'b0, div_dvs_reg}) : div_t[FW-1:0];
            div_lo_reg <= {div_lo_reg[FW-2:0], 1'b0};
            div_q_reg <= {div_q_reg[FW-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LATCH:
            begin
                op_reg <= in_op;
                e_reg <= in_e;
                path_reg <= in_path;
                step_reg <= in_step;
                dist_reg <= in_path;
            end
            CMD_SET_STEPS:
            begin
                steps_reg <= SW'(div_q_reg);
                cnt_reg <= '0;
            end
            CMD_SET_SEG:  dist_reg <= div_q_reg;
            CMD_MUL_REM:  prod_reg <= PW'(MA'(steps_reg) * step_reg);
            CMD_SET_REM:  dist_reg <= path_reg - prod_reg[FW-1:0];
            CMD_SINIT:
            begin
                p_reg <= p_start;
                phase2_reg <= 1'b0;
            end
            CMD_SWRAP:
            begin
                p_reg <= '0;
                phase2_reg <= 1'b1;
            end
            CMD_SNEXT:    p_reg <= p_inc;
            CMD_MUL_E:
            begin
                prod_reg <= PW'(num * dya);
                neg_reg <= (rd_a1 < rd_a0);
            end
            CMD_SET_SE:   se_reg <= neg_reg ? rd_a0 - div_q_reg : rd_a0 + div_q_reg;
            CMD_MUL_N:
            begin
                prod_reg <= PW'(num * dyn);
                neg_reg <= (rd_n1 < rd_n0);
            end
            CMD_SET_SN:   sn_reg <= neg_reg ? rd_n0 - div_q_reg : rd_n0 + div_q_reg;
            CMD_SUM10:    sum10_reg <= (MA'(sum_se) << 3) + (MA'(sum_se) << 1);
            CMD_MUL_LOSS: prod_reg <= sum10_reg * dist_reg;
            CMD_APPLY:
            begin
                if (op_reg == OP_INITIAL)
                    e_reg <= sum_e[FW] ? {FW{1'b1}} : sum_e[FW-1:0];
                else
                    e_reg <= (loss > e_reg) ? '0 : e_reg - loss;
                cnt_reg <= cnt_reg + SW'(1);
            end
            CMD_OUT_OK:
            begin
                res_reg <= (op_reg == OP_LOSS) ? loss : e_reg;
                st_reg <= ST_OK;
            end
            CMD_OUT_OOR:
            begin
                res_reg <= '0;
                st_reg <= ST_OUT_OF_RANGE;
            end
            CMD_OUT_TMS:
            begin
                res_reg <= '0;
                st_reg <= ST_TOO_MANY;
            end
            default: ;
        endcase
    end

    assign result_energy = res_reg;
    assign result_status = st_reg;

`ifndef NO_ASSERTIONS
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy_reg)
        else $error("divider started while busy");
    a_steps_checked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_SET_STEPS) |-> (!div_busy_reg && 32'(div_q_reg) <= MAX_STEPS))
        else $error("step count taken before it was checked");
    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_SHIT) |-> (pp1 < rows_eff))
        else $error("interval found beyond the rows in use");
`endif

endmodule

FILE: rtl/stopping_power_energy_stepper_core.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser: operation; tdata: row_index, row_energy, row_electronic_power,
//                row_nuclear_power, ion_energy, path_length, step_size
// m_axis    out  tuser: status; tdata: result_energy
// cfg       in   cfg_data: rows_in_use
//
// A load is taken in the idle state and gives no result. A query scans the table rows
// for its interval and then interpolates with two serial 24-bit divisions; the modes
// that step run that once per step plus the remainder step, after two more
// 24-bit divisions. The search scan and the serial divider set the query time.
// Reset is asynchronous and clears the control state and the search hint;
// table rows stay undefined until loaded. A stalled result does not block
// the controller until the next result is ready.
module stopping_power_energy_stepper_core
    import spe_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_STEPS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // row_index, row_energy, row_electronic_power, row_nuclear_power,
    // ion_energy, path_length, step_size
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // operation
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result_energy
    output logic [FW-1:0]        m_axis_tdata,
    // status
    output logic [1:0]           m_axis_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ROWS_W-1:0]    cfg_data
);

    cmd_t cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    spe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    spe_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_STEPS   (MAX_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_op         (s_axis_tuser),
        .in_data       (s_axis_tdata),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .st            (st),
        .result_energy (m_axis_tdata),
        .result_status (m_axis_tuser)
    );

endmodule

FILE: sim/stopping_power_energy_stepper_checker.sv
`timescale 1ns / 1ps

module stopping_power_energy_stepper_checker
    import spe_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_STEPS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [FW-1:0]        m_axis_tdata,
    input  logic [1:0]           m_axis_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [ROWS_W-1:0]    cfg_data,
    output int                   failures,
    output int                   pending
);

    typedef struct {
        logic [FW-1:0] energy;
        logic [1:0]    status;
    } outcome_t;

    localparam longint unsigned SAT = 64'hFF_FFFF;

    logic [FW-1:0] energy_rows [TABLE_DEPTH];
    logic [FW-1:0] elec_rows [TABLE_DEPTH];
    logic [FW-1:0] nuc_rows [TABLE_DEPTH];
    int unsigned   hint;
    int unsigned   rows_cfg;
    outcome_t      expected_results [$];

    assign pending = expected_results.size();

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        failures++;
    endtask

    function automatic bit locate_interval(input longint unsigned e, output int unsigned lo);
        int unsigned rows;
        int unsigned p;
        rows = rows_cfg > TABLE_DEPTH ? TABLE_DEPTH : rows_cfg;
        lo = 0;
        if (rows < 2)
            return 0;
        for (p = (hint > 0 ? hint - 1 : 0); p + 1 < rows; p++)
            if (e >= energy_rows[p] && e < energy_rows[p+1])
            begin
                lo = p;
                hint = p;
                return 1;
            end
        for (p = 0; p + 1 < hint && p + 1 < rows; p++)
            if (e >= energy_rows[p] && e < energy_rows[p+1])
            begin
                lo = p;
                hint = p;
                return 1;
            end
        return 0;
    endfunction

    function automatic longint unsigned lerp(input longint unsigned y1, input longint unsigned y2,
                                             input longint unsigned num,
                                             input longint unsigned den);
        if (y2 >= y1)
            return y1 + (num * (y2 - y1)) / den;
        return y1 - (num * (y1 - y2)) / den;
    endfunction

    function automatic bit stopping_loss(input longint unsigned e,
                                         input longint unsigned span,
                                         output longint unsigned loss);
        int unsigned     p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned se;
        longint unsigned sn;
        longint unsigned prod;
        loss = 0;
        if (!locate_interval(e, p))
            return 0;
        num = e - energy_rows[p];
        den = energy_rows[p+1] - energy_rows[p];
        se = lerp(elec_rows[p], elec_rows[p+1], num, den);
        sn = lerp(nuc_rows[p], nuc_rows[p+1], num, den);
        prod = ((se + sn) * 10 * span) >> 16;
        loss = prod > SAT ? SAT : prod;
        return 1;
    endfunction

    // Returns 1 when the beat produces a result.
    function automatic bit predict_outcome(input logic [1:0] op,
                                           input logic [IN_DATA_W-1:0] d,
                                           output outcome_t res);
        longint unsigned e;
        longint unsigned path;
        longint unsigned stp;
        longint unsigned loss;
        longint unsigned steps;
        longint unsigned seg;
        longint unsigned s;
        bit              add;
        int unsigned     idx;
        idx = d[7:0];
        e = d[103:80];
        path = d[127:104];
        stp = d[151:128];
        res.energy = '0;
        res.status = ST_OK;
        if (op == OP_LOAD)
        begin
            energy_rows[idx] = d[31:8];
            elec_rows[idx] = d[55:32];
            nuc_rows[idx] = d[79:56];
            return 0;
        end
        if (op == OP_LOSS)
        begin
            if (stopping_loss(e, path, loss))
                res.energy = loss[FW-1:0];
            else
                res.status = ST_OUT_OF_RANGE;
            return 1;
        end
        add = (op == OP_INITIAL);
        if (add)
            hint = 0;
        if (stp == 0 || path / stp > MAX_STEPS)
        begin
            res.status = ST_TOO_MANY;
            return 1;
        end
        steps = path / stp;
        seg = steps > 0 ? path / steps : 0;
        // The regular steps come first, then one step over what is left of the path.
        for (s = 0; s <= steps; s++)
        begin
            if (!stopping_loss(e, s < steps ? seg : path - steps * stp, loss))
            begin
                res.status = ST_OUT_OF_RANGE;
                return 1;
            end
            if (add)
                e = (e + loss > SAT) ? SAT : e + loss;
            else
                e = (loss > e) ? 0 : e - loss;
        end
        res.energy = e[FW-1:0];
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t res;
        outcome_t want;
        if (!rst_n)
        begin
            hint = 0;
            rows_cfg = ROWS_RESET;
            failures = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rows_cfg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                if (predict_outcome(s_axis_tuser, s_axis_tdata, res))
                    expected_results.push_back(res);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result beat energy=%h status=%0d",
                                              m_axis_tdata, m_axis_tuser));
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata !== want.energy)
                        report_mismatch($sformatf("result_energy %h, expected %h",
                                                  m_axis_tdata, want.energy));
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_axis_tuser, want.status));
                end
            end
        end
    end

endmodule

FILE: sim/stopping_power_energy_stepper_core_tb.sv
`timescale 1ns / 1ps

module stopping_power_energy_stepper_core_tb;
    import spe_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [FW-1:0]        m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ROWS_W-1:0]    cfg_data;
    int                   failures;
    int                   pending;
    logic                 s_fire;
    logic                 c_fire;
    int                   send_idle;
    int                   recv_stall;
    int unsigned          rows_now;

    stopping_power_energy_stepper_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    stopping_power_energy_stepper_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Handshakes are captured at the rising edge and looked at on the falling edge.
    always @(posedge clk)
    begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        c_fire <= cfg_valid && cfg_ready;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);

    task automatic send_beat(input logic [1:0] op, input logic [7:0] idx,
                             input logic [23:0] re, input logic [23:0] rel,
                             input logic [23:0] rnu, input logic [23:0] ion,
                             input logic [23:0] path, input logic [23:0] stp);
        s_axis_tdata <= {stp, path, ion, rnu, rel, re, idx};
        s_axis_tuser <= op;
        s_axis_tvalid <= 1'b1;
        do @(negedge clk); while (!s_fire);
        if ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        // Loads give no result, so leave room for one still in flight.
        repeat (100) @(negedge clk);
    endtask

    task automatic write_rows(input int unsigned v);
        drain_results();
        cfg_data <= v[ROWS_W-1:0];
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!c_fire);
        cfg_valid <= 1'b0;
        rows_now = v;
    endtask

    task automatic random_beat();
        int unsigned   pick;
        logic [23:0]   stp;
        logic [23:0]   path;
        logic [23:0]   ion;
        logic [7:0]    idx;
        int unsigned   top;
        pick = $urandom_range(0, 99);
        top = (rows_now - 1) * 32'h80000;
        if (top > 24'hFFFFFF)
            top = 24'hFFFFFF;
        ion = ($urandom_range(0, 9) < 8) ? 24'($urandom_range(0, top)) : 24'($urandom);
        stp = 24'($urandom_range(16'h0100, 24'h3FFFF));
        path = 24'(stp * $urandom_range(0, 12) + $urandom_range(0, stp - 1));
        if ($urandom_range(0, 19) == 0)
        begin
            // Noise: a zero step, or a path and step taken from all codes.
            stp = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom);
            path = 24'($urandom);
        end
        idx = 8'($urandom);
        if (pick < 15)
            send_beat(OP_LOAD, idx, 24'(idx * 32'h80000 + $urandom_range(0, 32'h7FFFF)),
                      24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 16'hFFFF)),
                      24'($urandom_range(0, 16'h0FFF)), 24'($urandom), 24'($urandom),
                      24'($urandom));
        else if (pick < 45)
            send_beat(OP_LOSS, idx, 24'($urandom), 24'($urandom), 24'($urandom), ion,
                      24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 24'h3FFFF)),
                      stp);
        else if (pick < 75)
            send_beat(OP_FINAL, idx, 24'($urandom), 24'($urandom), 24'($urandom), ion,
                      path, stp);
        else
            send_beat(OP_INITIAL, idx, 24'($urandom), 24'($urandom), 24'($urandom), ion,
                      path, stp);
    endtask

    initial
    begin
        int i;
        int ph;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = ROWS_RESET;
        send_idle = 13;
        recv_stall = 68;
        rows_now = ROWS_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the rows in use with rising energies; row 12 carries saturating powers, row 31 a saturating nuclear one.
        for (i = 0; i < 32; i++)
            if (i == 31)
                send_beat(OP_LOAD, 8'd31, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                          24'd0, 24'd0, 24'd1);
            else if (i == 12)
                send_beat(OP_LOAD, 8'd12, 24'h600000, 24'hFFFFFF, 24'hFFFFFF,
                          24'd0, 24'd0, 24'd1);
            else
                send_beat(OP_LOAD, 8'(i),
                          24'(i * 32'h80000 + (i == 0 ? 0 : $urandom_range(0, 32'h7FFFF))),
                          24'($urandom_range(0, 16'hFFFF)), 24'($urandom_range(0, 16'h0FFF)),
                          24'd0, 24'd0, 24'd1);

        // With the reset row count only the first interval exists.
        send_beat(OP_LOSS, 8'd0, 24'd0, 24'd0, 24'd0, 24'h000000, 24'h010000, 24'd1);
        send_beat(OP_LOSS, 8'd0, 24'd0, 24'd0, 24'd0, 24'h018000, 24'h010000, 24'd1);
        write_rows(32);
        send_beat(OP_LOSS, 8'd0, 24'd0, 24'd0, 24'd0, 24'h640000, 24'h000000, 24'd1);
        send_beat(OP_LOSS, 8'd0, 24'd0, 24'd0, 24'd0, 24'h640000, 24'hFFFFFF, 24'd1);
        send_beat(OP_LOSS, 8'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'h010000, 24'd1);
        send_beat(OP_LOSS, 8'd0, 24'd0, 24'd0, 24'd0, 24'hF00000, 24'h001000, 24'd1);
        // A low energy right after a high one forces the search to wrap.
        send_beat(OP_LOSS, 8'd0, 24'd0, 24'd0, 24'd0, 24'h028000, 24'h001000, 24'd1);
        send_beat(OP_FINAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'h800000, 24'h010000, 24'h000000);
        send_beat(OP_FINAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'h800000, 24'h000401, 24'h000001);
        send_beat(OP_INITIAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'h300000, 24'h000400, 24'h000001);
        send_beat(OP_FINAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'h200000, 24'h000800, 24'h010000);
        send_beat(OP_FINAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'h650000, 24'h080000, 24'h010000);
        send_beat(OP_INITIAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'h630000, 24'h080000, 24'h010000);
        send_beat(OP_INITIAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'hFE8000, 24'h040000, 24'h008000);
        send_beat(OP_FINAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'h000000, 24'h001000, 24'h000400);
        send_beat(OP_FINAL, 8'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);

        for (ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 13 : (ph == 1) ? 68 : 0;
            recv_stall = (ph == 0) ? 68 : (ph == 1) ? 13 : 0;
            write_rows((ph == 0) ? 2 : (ph == 1) ? $urandom_range(3, 31) : 32);
            for (i = 0; i < 30; i++)
            begin
                if (ph == 1 && i == 20)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (pending != 0) @(negedge clk);
                end
                random_beat();
            end
        end

        drain_results();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
